// File: sv/svr_pkg.sv
// Shared types, codes and constants of the stepping supply regulator.
package svr_pkg;

    typedef enum logic [1:0] {
        KEY_NONE   = 2'd0,
        KEY_UP     = 2'd1,
        KEY_DOWN   = 2'd2,
        KEY_TOGGLE = 2'd3
    } key_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OCP    = 3'd0,
        CFG_OVP    = 3'd1,
        CFG_TMAX   = 3'd2,
        CFG_FINE   = 3'd3,
        CFG_COARSE = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [11:0] curr_adc_code;
        logic [11:0] volt_adc_code;
        key_t        key_event;
    } in_t;

    typedef struct packed {
        logic        coarse_mode;
        logic [11:0] iout_ma;
        logic [13:0] vout_mv;
        logic [13:0] target_mv;
        logic        fault_latched;
        logic [11:0] dac_code;
    } res_t;

    typedef struct packed {
        key_t        key;
        logic [11:0] iout;
    } side_t;

    localparam int IN_W       = $bits(in_t);
    localparam int S_TDATA_W  = 32;
    localparam int RES_W      = $bits(res_t);
    localparam int M_TDATA_W  = 56;

    localparam int SC_STAGES   = 4;
    localparam int SQ_STEPS    = 16;
    localparam int VC_STAGES   = SQ_STEPS + 4;
    localparam int PIPE_STAGES = SC_STAGES + VC_STAGES;

    localparam logic [11:0] OCP_RST    = 12'd1250;
    localparam logic [13:0] OVP_RST    = 14'd12300;
    localparam logic [13:0] TMAX_RST   = 14'd12000;
    localparam logic [9:0]  FINE_RST   = 10'd100;
    localparam logic [11:0] COARSE_RST = 12'd1000;

    localparam logic [11:0] DAC_MAX = 12'd4000;

endpackage

// File: sv/svr_scale.sv
// ADC code scaling: clamp, code-to-millivolt divide, current conversion.
module svr_scale #(
    parameter int unsigned ADC_CODE_MAX = 4095
) (
    input  logic                           aclk,
    input  logic [svr_pkg::SC_STAGES-1:0]  en,
    input  svr_pkg::in_t                   in_beat,
    output svr_pkg::key_t                  key,
    output logic [13:0]                    raw_mv,
    output logic [11:0]                    iout_ma
);
    import svr_pkg::*;

    localparam logic [16:0] CODE_MAX = 17'(ADC_CODE_MAX);
    localparam int unsigned RECIP    = (32'd1 << 24) / ADC_CODE_MAX;
    localparam logic [16:0] RECIP_W  = 17'(RECIP);
    localparam logic [17:0] IOUT_RECIP = 18'd135301;

    logic [11:0] vcode, icode;

    key_t        key1_reg, key2_reg, key3_reg, key4_reg;
    logic [23:0] vx1_reg, ix1_reg, vx2_reg, ix2_reg;
    logic [11:0] vqa2_reg, iqa2_reg;
    logic [11:0] vmv3_reg, imv3_reg;
    logic [13:0] raw4_reg;
    logic [11:0] iout4_reg;

    logic [40:0] vqa_prod, iqa_prod;
    logic [28:0] vqd, iqd;
    logic [23:0] vrem, irem;
    logic [11:0] vmv_next, imv_next;
    logic [16:0] iy;
    logic [34:0] ip;
    logic [11:0] iq, iout_next;

    assign vcode = ({5'b0, in_beat.volt_adc_code} > CODE_MAX) ? CODE_MAX[11:0]
                                                              : in_beat.volt_adc_code;
    assign icode = ({5'b0, in_beat.curr_adc_code} > CODE_MAX) ? CODE_MAX[11:0]
                                                              : in_beat.curr_adc_code;

    assign vqa_prod = 41'(vx1_reg) * 41'(RECIP_W);
    assign iqa_prod = 41'(ix1_reg) * 41'(RECIP_W);

    assign vqd      = 29'(vqa2_reg) * 29'(CODE_MAX);
    assign iqd      = 29'(iqa2_reg) * 29'(CODE_MAX);
    assign vrem     = vx2_reg - vqd[23:0];
    assign irem     = ix2_reg - iqd[23:0];
    assign vmv_next = vqa2_reg + 12'(vrem >= 24'(CODE_MAX));
    assign imv_next = iqa2_reg + 12'(irem >= 24'(CODE_MAX));

    assign iy        = 17'(imv3_reg) * 17'd20;
    assign ip        = 35'(iy) * 35'(IOUT_RECIP);
    assign iq        = ip[33:22];
    assign iout_next = (iq < 12'd10) ? 12'd0 : iq;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            key1_reg <= in_beat.key_event;
            vx1_reg  <= 24'(vcode) * 24'd3300;
            ix1_reg  <= 24'(icode) * 24'd3300;
        end
        if (en[1]) begin
            key2_reg <= key1_reg;
            vx2_reg  <= vx1_reg;
            ix2_reg  <= ix1_reg;
            vqa2_reg <= vqa_prod[35:24];
            iqa2_reg <= iqa_prod[35:24];
        end
        if (en[2]) begin
            key3_reg <= key2_reg;
            vmv3_reg <= vmv_next;
            imv3_reg <= imv_next;
        end
        if (en[3]) begin
            key4_reg  <= key3_reg;
            raw4_reg  <= {vmv3_reg, 2'b00};
            iout4_reg <= iout_next;
        end
    end

    assign key     = key4_reg;
    assign raw_mv  = raw4_reg;
    assign iout_ma = iout4_reg;

endmodule

// File: sv/svr_vcorr.sv
// Power-law voltage correction: log2 by repeated squaring, then correction factor.
module svr_vcorr (
    input  logic                           aclk,
    input  logic [svr_pkg::VC_STAGES-1:0]  en,
    input  logic [13:0]                    raw_mv,
    output logic [13:0]                    vout_mv
);
    import svr_pkg::*;

    localparam logic [19:0] LOG2_1000_Q16 = 20'd653117;
    localparam logic [23:0] KLN_Q32       = 24'd16725805;
    localparam int          T_ST          = SQ_STEPS + 1;
    localparam int          F_ST          = SQ_STEPS + 2;
    localparam int          V_ST          = SQ_STEPS + 3;

    logic [13:0] raw_reg  [0:SQ_STEPS];
    logic [3:0]  n_reg    [0:SQ_STEPS];
    logic [30:0] m_reg    [0:SQ_STEPS-1];
    logic [15:0] frac_reg [0:SQ_STEPS];

    logic [3:0]  lead_one;
    logic [30:0] m0_next;

    logic [19:0] lg, dmag;
    logic        pos;
    logic [43:0] tprod;
    logic [27:0] t_reg;
    logic        pos_reg;
    logic [13:0] raw_t_reg, raw_f_reg;
    logic [55:0] tsq;
    logic [22:0] q;
    logic [32:0] f_next, f_reg;
    logic [47:0] vprod;
    logic [13:0] vout_reg;

    always_comb begin
        lead_one = '0;
        for (int i = 0; i < 14; i++) begin
            if (raw_mv[i]) begin
                lead_one = 4'(i);
            end
        end
    end

    assign m0_next = 31'(raw_mv) << (5'd30 - {1'b0, lead_one});

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            raw_reg[0]  <= raw_mv;
            n_reg[0]    <= lead_one;
            m_reg[0]    <= m0_next;
            frac_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sq
        logic [61:0] sq_full;
        logic [31:0] sq_top;

        assign sq_full = 62'(m_reg[k-1]) * 62'(m_reg[k-1]);
        assign sq_top  = sq_full[61:30];

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                frac_reg[k] <= {frac_reg[k-1][14:0], sq_top[31]};
                n_reg[k]    <= n_reg[k-1];
                raw_reg[k]  <= raw_reg[k-1];
            end
        end

        if (k < SQ_STEPS) begin : g_m
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    m_reg[k] <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
                end
            end
        end
    end

    assign lg    = {n_reg[SQ_STEPS], frac_reg[SQ_STEPS]};
    assign pos   = lg > LOG2_1000_Q16;
    assign dmag  = pos ? (lg - LOG2_1000_Q16) : (LOG2_1000_Q16 - lg);
    assign tprod = 44'(dmag) * 44'(KLN_Q32);

    assign tsq    = 56'(t_reg) * 56'(t_reg);
    assign q      = tsq[55:33];
    assign f_next = pos_reg ? (33'h1_0000_0000 - 33'(t_reg) + 33'(q))
                            : (33'h1_0000_0000 + 33'(t_reg) + 33'(q));

    assign vprod = 48'(raw_f_reg) * 48'(f_reg) + 48'h0000_8000_0000;

    always_ff @(posedge aclk) begin
        if (en[T_ST]) begin
            t_reg     <= tprod[43:16];
            pos_reg   <= pos;
            raw_t_reg <= raw_reg[SQ_STEPS];
        end
        if (en[F_ST]) begin
            f_reg     <= f_next;
            raw_f_reg <= raw_t_reg;
        end
        if (en[V_ST]) begin
            vout_reg <= vprod[45:32];
        end
    end

    assign vout_mv = vout_reg;

endmodule

// File: sv/svr_ctrl.sv
// Configuration registers, key handling, protection latch and DAC stepping.
module svr_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr,
    input  logic [svr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [svr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            fire,
    input  svr_pkg::key_t                   key,
    input  logic [13:0]                     vout_mv,
    input  logic [11:0]                     iout_ma,
    output svr_pkg::res_t                   res
);
    import svr_pkg::*;

    logic [11:0] ocp_reg;
    logic [13:0] ovp_reg;
    logic [13:0] tmax_reg;
    logic [9:0]  fine_reg;
    logic [11:0] coarse_step_reg;

    logic [13:0] target_reg, target_next;
    logic [11:0] dac_reg, dac_next;
    logic        fault_reg, fault_next;
    logic        coarse_reg, coarse_next;
    logic [13:0] vout_out_reg;
    logic [11:0] iout_out_reg;

    logic [11:0]        step;
    logic [14:0]        up_sum;
    logic signed [15:0] err;
    logic signed [5:0]  dstep;
    logic signed [13:0] dac_sum;

    always_comb begin
        step        = coarse_reg ? coarse_step_reg : {2'b00, fine_reg};
        target_next = target_reg;
        dac_next    = dac_reg;
        fault_next  = fault_reg;
        coarse_next = coarse_reg;

        case (key) inside
            KEY_UP, KEY_DOWN: begin
                if (fault_next) begin
                    fault_next  = 1'b0;
                    target_next = '0;
                    dac_next    = '0;
                end
            end
            KEY_TOGGLE: begin
                coarse_next = ~coarse_reg;
            end
            default: ;
        endcase

        up_sum = 15'(target_next) + 15'(step);
        if (key == KEY_UP) begin
            target_next = (up_sum <= 15'(tmax_reg)) ? up_sum[13:0] : tmax_reg;
        end else if (key == KEY_DOWN) begin
            target_next = (target_next >= 14'(step)) ? target_next - 14'(step) : 14'd0;
        end

        if (iout_ma > ocp_reg || vout_mv > ovp_reg) begin
            fault_next  = 1'b1;
            target_next = '0;
            dac_next    = '0;
        end

        err = $signed({2'b00, target_next}) - $signed({2'b00, vout_mv});
        if (err > 16'sd1200) begin
            dstep = 6'sd24;
        end else if (err > 16'sd500) begin
            dstep = 6'sd10;
        end else if (err > 16'sd150) begin
            dstep = 6'sd4;
        end else if (err > 16'sd60) begin
            dstep = 6'sd2;
        end else if (err > 16'sd40) begin
            dstep = 6'sd1;
        end else if (err < -16'sd1200) begin
            dstep = -6'sd24;
        end else if (err < -16'sd500) begin
            dstep = -6'sd10;
        end else if (err < -16'sd150) begin
            dstep = -6'sd4;
        end else if (err < -16'sd60) begin
            dstep = -6'sd2;
        end else if (err < -16'sd40) begin
            dstep = -6'sd1;
        end else begin
            dstep = 6'sd0;
        end

        dac_sum = $signed({2'b00, dac_next}) + 14'(dstep);
        if (!fault_next) begin
            if (dac_sum < 14'sd0) begin
                dac_next = '0;
            end else if (dac_sum > $signed({2'b00, DAC_MAX})) begin
                dac_next = DAC_MAX;
            end else begin
                dac_next = dac_sum[11:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocp_reg         <= OCP_RST;
            ovp_reg         <= OVP_RST;
            tmax_reg        <= TMAX_RST;
            fine_reg        <= FINE_RST;
            coarse_step_reg <= COARSE_RST;
            target_reg      <= '0;
            dac_reg         <= '0;
            fault_reg       <= 1'b0;
            coarse_reg      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_OCP:    ocp_reg         <= cfg_data[11:0];
                    CFG_OVP:    ovp_reg         <= cfg_data[13:0];
                    CFG_TMAX:   tmax_reg        <= cfg_data[13:0];
                    CFG_FINE:   fine_reg        <= cfg_data[9:0];
                    CFG_COARSE: coarse_step_reg <= cfg_data[11:0];
                    default: ;
                endcase
            end
            if (fire) begin
                target_reg <= target_next;
                dac_reg    <= dac_next;
                fault_reg  <= fault_next;
                coarse_reg <= coarse_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            vout_out_reg <= vout_mv;
            iout_out_reg <= iout_ma;
        end
    end

    assign res.coarse_mode   = coarse_reg;
    assign res.iout_ma       = iout_out_reg;
    assign res.vout_mv       = vout_out_reg;
    assign res.target_mv     = target_reg;
    assign res.fault_latched = fault_reg;
    assign res.dac_code      = dac_reg;

endmodule

// File: sv/supply_voltage_stepping_regulator.sv
// Top level of the stepping supply regulator: stream ports, pipeline control, datapath.
//
//   channel   direction  ports                                  beat
//   s_        in         s_tvalid s_tready s_tdata[31:0]        one control tick
//   m_        out        m_tvalid m_tready m_tdata[55:0]        one result per tick
//   cfg_      in         cfg_valid cfg_ready cfg_index cfg_data one register write
//
// One beat is taken per cycle while s_tready is high; beats follow one another through the pipeline.
// Most of the pipeline is the 16-step squaring chain of the log2 in the voltage correction.
// Reset (aresetn low, synchronous) empties the pipeline, zeroes the state and
// loads the register defaults; cfg_ready is always high.
// A stalled result holds m_tdata; empty pipeline slots keep s_tready high until
// every slot between input and output is full.
module supply_voltage_stepping_regulator #(
    parameter int unsigned ADC_CODE_MAX = 4095
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [svr_pkg::S_TDATA_W-1:0]   s_tdata,   // key_event, volt_adc_code, curr_adc_code
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [svr_pkg::M_TDATA_W-1:0]   m_tdata,   // dac_code, fault_latched, target_mv,
                                                       // vout_mv, iout_ma, coarse_mode
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [svr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [svr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import svr_pkg::*;

    localparam logic [PIPE_STAGES-1:0] PIPE_ONE = PIPE_STAGES'(1);

    logic [PIPE_STAGES-1:0] occ_reg, occ_next;
    logic [PIPE_STAGES-1:0] free;
    logic                   free_out;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   fire;

    in_t         in_beat;
    key_t        sc_key;
    logic [13:0] sc_raw_mv;
    logic [11:0] sc_iout_ma;
    logic [13:0] vc_vout_mv;
    side_t       side_reg [0:VC_STAGES-1];
    res_t        res;

    always_comb begin
        free_out = !m_tvalid_reg || m_tready;
        for (int i = 0; i < PIPE_STAGES; i++) begin
            free[i] = free_out || ((occ_reg | ((PIPE_ONE << i) - PIPE_ONE)) != '1);
        end
    end

    always_comb begin
        occ_next[0] = free[0] ? s_tvalid : occ_reg[0];
        for (int i = 1; i < PIPE_STAGES; i++) begin
            occ_next[i] = free[i] ? occ_reg[i-1] : occ_reg[i];
        end
        m_tvalid_next = free_out ? occ_reg[PIPE_STAGES-1] : m_tvalid_reg;
    end

    assign fire = free_out && occ_reg[PIPE_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            occ_reg      <= occ_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign in_beat = in_t'(s_tdata[IN_W-1:0]);

    svr_scale #(
        .ADC_CODE_MAX (ADC_CODE_MAX)
    ) u_scale (
        .aclk    (aclk),
        .en      (free[SC_STAGES-1:0]),
        .in_beat (in_beat),
        .key     (sc_key),
        .raw_mv  (sc_raw_mv),
        .iout_ma (sc_iout_ma)
    );

    svr_vcorr u_vcorr (
        .aclk    (aclk),
        .en      (free[PIPE_STAGES-1:SC_STAGES]),
        .raw_mv  (sc_raw_mv),
        .vout_mv (vc_vout_mv)
    );

    always_ff @(posedge aclk) begin
        if (free[SC_STAGES]) begin
            side_reg[0] <= '{key: sc_key, iout: sc_iout_ma};
        end
    end

    for (genvar j = 1; j < VC_STAGES; j++) begin : g_side
        always_ff @(posedge aclk) begin
            if (free[SC_STAGES+j]) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    svr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .key       (side_reg[VC_STAGES-1].key),
        .vout_mv   (vc_vout_mv),
        .iout_ma   (side_reg[VC_STAGES-1].iout),
        .res       (res)
    );

    assign s_tready  = free[0];
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {(M_TDATA_W - RES_W)'(0), res};
    assign cfg_ready = 1'b1;

endmodule

// File: sv/svr_checker.sv
// Port-level checks of the stepping supply regulator, bound to the top level.
module svr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [svr_pkg::M_TDATA_W-1:0]   m_tdata
);
    import svr_pkg::*;

    res_t r;

    assign r = res_t'(m_tdata[RES_W-1:0]);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_fault_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.fault_latched |-> r.dac_code == '0 && r.target_mv == '0)
        else $error("latched fault with output not shut down");

    a_dac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> r.dac_code <= DAC_MAX)
        else $error("dac code above ceiling");

    a_iout_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (r.iout_ma == '0 || r.iout_ma >= 12'd10))
        else $error("current reading below floor not forced to zero");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind supply_voltage_stepping_regulator svr_checker u_svr_checker (.*);
